// ===== rtl/cel_pkg.sv =====
// Shared types, widths and codes of the cosine embedding loss block.
package cel_pkg;

  // Input word: one element pair of the two embedding vectors.
  typedef struct packed {
    logic signed [15:0] first_elem;
    logic signed [15:0] second_elem;
    logic               target_positive;
    logic               final_elem;
  } cel_in_t;

  // Output word: loss and gradients for one element.
  typedef struct packed {
    logic        [15:0] loss_q14;
    logic signed [31:0] grad_first;
    logic signed [31:0] grad_second;
    logic        [4:0]  elem_index;
    logic               last_result;
  } cel_out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VECTOR_LENGTH = 2'd0,
    CFG_MARGIN        = 2'd1,
    CFG_EPS           = 2'd2,
    CFG_GRAD_SCALE    = 2'd3
  } cfg_reg_e;

  // Divider operations: which numerator, denominator and destination.
  typedef enum logic [2:0] {
    DIV_COS       = 3'd0,
    DIV_T1_FIRST  = 3'd1,
    DIV_T2_FIRST  = 3'd2,
    DIV_T1_SECOND = 3'd3,
    DIV_T2_SECOND = 3'd4
  } div_op_e;

  localparam int DivNumW = 64;  // dividend width
  localparam int DivDenW = 50;  // divisor width (product of two roots)
  localparam int SqrtW   = 50;  // radicand width (norm shifted by 12)
  localparam int RootW   = 25;  // root width
  localparam int AccW    = 40;  // accumulator width
  localparam int NormW   = 38;  // norm plus eps
  localparam int TermW   = 46;  // one gradient term
  localparam int GradW   = 47;  // difference of two terms
  localparam int ProdW   = 62;  // gradient magnitude times scale
  localparam int CosOne  = 16384;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    acc_en;
    logic    clr;
    logic    prep;
    logic    idx_clr;
    logic    idx_inc;
    logic    sqrt_start;
    logic    sqrt_sel_b;
    logic    d_ld;
    logic    div_start;
    div_op_e div_op;
    logic    loss_ld;
    logic    rd_en;
    logic    prod_ld;
    logic    g_ld;
    logic    scale_ld;
    logic    out_ld;
  } cel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_end;
    logic sqrt_done;
    logic div_done;
    logic idx_last;
    logic out_free;
  } cel_status_t;

endpackage

// ===== rtl/cel_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cel_div import cel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  localparam int CntW = $clog2(DivNumW);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [DivNumW-1:0] quo_q;

  logic [DivDenW:0]   trial, diff;
  logic               ge;

  // One trial subtraction.
  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/cel_sqrt.sv =====
// Integer square root, one result bit per cycle.
module cel_sqrt import cel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqrtW-1:0] rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic             busy_q, done_q;
  logic [SqrtW-1:0] n_q, res_q, bit_q;
  logic [SqrtW-1:0] sum;
  logic             ge;

  always_comb begin
    sum = res_q + bit_q;
    ge  = n_q >= sum;
  end

  // Control: the last step is the one with the lowest bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Remainder, partial root and current bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= rad_i;
      res_q <= '0;
      bit_q <= SqrtW'(1) << (SqrtW - 2);
    end else if (busy_q) begin
      n_q   <= ge ? n_q - sum : n_q;
      res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ===== rtl/cel_datapath.sv =====
// Datapath: configuration, element stores, accumulators, arithmetic units, output word.
module cel_datapath import cel_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  cel_in_t     in_word_i,
  input  cel_cmd_t    cmd_i,
  output cel_status_t status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output cel_out_t    out_word_o
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam logic [7:0] MaxLen = 8'(MAX_DIM);

  // Saturate a scaled gradient magnitude to 32 bits with its sign; zero when act is low.
  function automatic logic signed [31:0] sat_grad(logic [ProdW-9:0] v, logic neg,
                                                  logic act);
    logic signed [31:0] r;
    if (!act) begin
      r = '0;
    end else if (neg) begin
      r = (v >= (ProdW-8)'(33'h8000_0000)) ? 32'sh8000_0000 : -$signed(v[31:0]);
    end else begin
      r = (v > (ProdW-8)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(v[31:0]);
    end
    return r;
  endfunction

  // Configuration registers.
  logic        [5:0]  vlen_q;
  logic signed [15:0] margin_q;
  logic        [15:0] eps_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q   <= 6'd32;
      margin_q <= '0;
      eps_q    <= 16'd1;
      scale_q  <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_VECTOR_LENGTH: vlen_q   <= cfg_data_i[5:0];
        CFG_MARGIN:        margin_q <= $signed(cfg_data_i);
        CFG_EPS:           eps_q    <= cfg_data_i;
        CFG_GRAD_SCALE:    scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective length and end of run.
  logic [7:0]    len_eff, count_inc;
  logic [CW-1:0] count_q, idx_q;

  always_comb begin
    len_eff = {2'b00, vlen_q};
    if (len_eff == 8'd0) len_eff = 8'd1;
    if (len_eff > MaxLen) len_eff = MaxLen;
    count_inc = 8'(count_q) + 8'd1;
  end

  // Accumulators and element count.
  logic signed [AccW-1:0] dot_q, fsq_q, ssq_q;
  logic                   target_q;
  logic signed [31:0]     p_dot, p_ff, p_ss;

  always_comb begin
    p_dot = in_word_i.first_elem * in_word_i.second_elem;
    p_ff  = in_word_i.first_elem * in_word_i.first_elem;
    p_ss  = in_word_i.second_elem * in_word_i.second_elem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q    <= '0;
      fsq_q    <= '0;
      ssq_q    <= '0;
      count_q  <= '0;
      target_q <= 1'b0;
    end else if (cmd_i.clr) begin
      dot_q   <= '0;
      fsq_q   <= '0;
      ssq_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.acc_en) begin
      dot_q    <= dot_q + AccW'(p_dot);
      fsq_q    <= fsq_q + AccW'(p_ff);
      ssq_q    <= ssq_q + AccW'(p_ss);
      count_q  <= count_q + CW'(1);
      target_q <= in_word_i.target_positive;
    end
  end

  // Element stores: written on accept, read one element at a time.
  logic signed [15:0] first_mem [MAX_DIM];
  logic signed [15:0] second_mem [MAX_DIM];
  logic signed [15:0] fx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      first_mem[count_q[AW-1:0]]  <= in_word_i.first_elem;
      second_mem[count_q[AW-1:0]] <= in_word_i.second_elem;
    end
    if (cmd_i.rd_en) begin
      fx_q <= first_mem[idx_q[AW-1:0]];
      sy_q <= second_mem[idx_q[AW-1:0]];
    end
  end

  // Element index for the output loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CW'(1);
    end
  end

  // Norms plus eps.
  logic [NormW-1:0] a_q, b_q;
  logic [15:0]      eps_eff;

  assign eps_eff = (eps_q == 16'd0) ? 16'd1 : eps_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      a_q <= NormW'(fsq_q) + NormW'(eps_eff);
      b_q <= NormW'(ssq_q) + NormW'(eps_eff);
    end
  end

  // Square roots and their product.
  logic             sqrt_done;
  logic [RootW-1:0] root, sa_q, sb_q;
  logic [SqrtW-1:0] rad;
  logic [DivDenW-1:0] d_q;

  assign rad = cmd_i.sqrt_sel_b ? {b_q, 12'b0} : {a_q, 12'b0};

  cel_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    if (sqrt_done) begin
      if (cmd_i.sqrt_sel_b) sb_q <= root;
      else                  sa_q <= root;
    end
    if (cmd_i.d_ld) d_q <= DivDenW'(sa_q) * DivDenW'(sb_q);
  end

  // Divider operand selection.
  logic signed [31:0]   cx_q, cy_q;
  logic [AccW-1:0]      dot_mag;
  logic [16:0]          fx_mag, sy_mag;
  logic [31:0]          cx_mag, cy_mag;
  logic [DivNumW-1:0]   div_num, quot;
  logic [DivDenW-1:0]   div_den;
  logic                 div_done, div_neg;

  always_comb begin
    dot_mag = dot_q[AccW-1] ? AccW'(-dot_q) : AccW'(dot_q);
    fx_mag  = fx_q[15] ? 17'(-18'(fx_q)) : 17'(fx_q);
    sy_mag  = sy_q[15] ? 17'(-18'(sy_q)) : 17'(sy_q);
    cx_mag  = cx_q[31] ? 32'(-cx_q) : 32'(cx_q);
    cy_mag  = cy_q[31] ? 32'(-cy_q) : 32'(cy_q);
    case (cmd_i.div_op)
      DIV_COS: begin
        div_num = DivNumW'(dot_mag) << 26;
        div_den = d_q;
        div_neg = dot_q[AccW-1];
      end
      DIV_T1_FIRST: begin
        div_num = DivNumW'(sy_mag) << 40;
        div_den = d_q;
        div_neg = sy_q[15];
      end
      DIV_T2_FIRST: begin
        div_num = DivNumW'(cx_mag) << 14;
        div_den = DivDenW'(a_q);
        div_neg = cx_q[31];
      end
      DIV_T1_SECOND: begin
        div_num = DivNumW'(fx_mag) << 40;
        div_den = d_q;
        div_neg = fx_q[15];
      end
      DIV_T2_SECOND: begin
        div_num = DivNumW'(cy_mag) << 14;
        div_den = DivDenW'(b_q);
        div_neg = cy_q[31];
      end
      default: begin
        div_num = '0;
        div_den = d_q;
        div_neg = 1'b0;
      end
    endcase
  end

  cel_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Quotients with sign: the cosine is clamped to one.
  logic signed [15:0]    cos_q;
  logic signed [TermW-1:0] t1f_q, t2f_q, t1s_q, t2s_q, term;
  logic [14:0]           cos_mag;

  always_comb begin
    cos_mag = (quot > DivNumW'(CosOne)) ? 15'(CosOne) : quot[14:0];
    term    = div_neg ? -$signed(TermW'(quot)) : $signed(TermW'(quot));
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (cmd_i.div_op)
        DIV_COS:       cos_q <= div_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        DIV_T1_FIRST:  t1f_q <= term;
        DIV_T2_FIRST:  t2f_q <= term;
        DIV_T1_SECOND: t1s_q <= term;
        DIV_T2_SECOND: t2s_q <= term;
        default: ;
      endcase
    end
  end

  // Loss and gradient direction.
  logic        [15:0] loss_q;
  logic               dl_act_q, dl_neg_q;
  logic signed [16:0] cos17, lim;
  logic        [16:0] loss_n;

  always_comb begin
    cos17 = 17'(cos_q);
    lim   = cos17 - 17'(margin_q);
    if (target_q) begin
      loss_n = 17'(17'sd16384 - cos17);
    end else begin
      loss_n = (lim > 17'sd0) ? 17'(lim) : 17'd0;
    end
    if (loss_n > 17'd32768) loss_n = 17'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.loss_ld) begin
      loss_q   <= loss_n[15:0];
      dl_act_q <= target_q | (cos17 > 17'(margin_q));
      dl_neg_q <= target_q;
    end
  end

  // Gradient terms, differences and scaling.
  logic signed [GradW-1:0] g1_q, g2_q;
  logic [GradW-2:0]        g1_mag, g2_mag;
  logic [ProdW-1:0]        p1_q, p2_q;
  logic                    n1_q, n2_q;

  always_comb begin
    g1_mag = g1_q[GradW-1] ? (GradW-1)'(-g1_q) : (GradW-1)'(g1_q);
    g2_mag = g2_q[GradW-1] ? (GradW-1)'(-g2_q) : (GradW-1)'(g2_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_ld) begin
      cx_q <= cos_q * fx_q;
      cy_q <= cos_q * sy_q;
    end
    if (cmd_i.g_ld) begin
      g1_q <= GradW'(t1f_q) - GradW'(t2f_q);
      g2_q <= GradW'(t1s_q) - GradW'(t2s_q);
    end
    if (cmd_i.scale_ld) begin
      p1_q <= g1_mag * scale_q;
      p2_q <= g2_mag * scale_q;
      n1_q <= g1_q[GradW-1] ^ dl_neg_q;
      n2_q <= g2_q[GradW-1] ^ dl_neg_q;
    end
  end

  // Output register.
  logic     out_valid_q;
  cel_out_t out_word_q;
  logic     idx_last;

  assign idx_last = (idx_q + CW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_word_q.loss_q14    <= loss_q;
      out_word_q.grad_first  <= sat_grad(p1_q[ProdW-1:8], n1_q, dl_act_q);
      out_word_q.grad_second <= sat_grad(p2_q[ProdW-1:8], n2_q, dl_act_q);
      out_word_q.elem_index  <= 5'(idx_q);
      out_word_q.last_result <= idx_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Status.
  always_comb begin
    status_o.run_end   = in_word_i.final_elem | (count_inc >= len_eff);
    status_o.sqrt_done = sqrt_done;
    status_o.div_done  = div_done;
    status_o.idx_last  = idx_last;
    status_o.out_free  = !out_valid_q | !out_stall_i;
  end

endmodule

// ===== rtl/cel_ctrl.sv =====
// Controller: sequences accumulation, roots, divisions and result emission.
module cel_ctrl import cel_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cel_status_t status_i,
  output cel_cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    S_ACCUM = 16'h0001,
    S_PREP  = 16'h0002,
    S_SQA   = 16'h0004,
    S_SQB   = 16'h0008,
    S_MUL   = 16'h0010,
    S_DCOS  = 16'h0020,
    S_LOSS  = 16'h0040,
    S_RD    = 16'h0080,
    S_LD    = 16'h0100,
    S_D1    = 16'h0200,
    S_D2    = 16'h0400,
    S_D3    = 16'h0800,
    S_D4    = 16'h1000,
    S_GSUB  = 16'h2000,
    S_SCL   = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_ACCUM;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Next state and commands. Wait states start their unit once, then wait for done.
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.div_op = DIV_COS;
    case (state_q)
      S_ACCUM: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (status_i.run_end) state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep    = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = S_SQA;
      end
      S_SQA, S_SQB: begin
        cmd_o.sqrt_sel_b = (state_q == S_SQB);
        if (!issued_q) begin
          cmd_o.sqrt_start = 1'b1;
          issued_d         = 1'b1;
        end else if (status_i.sqrt_done) begin
          issued_d = 1'b0;
          state_d  = (state_q == S_SQB) ? S_MUL : S_SQB;
        end
      end
      S_MUL: begin
        cmd_o.d_ld = 1'b1;
        state_d    = S_DCOS;
      end
      S_DCOS, S_D1, S_D2, S_D3, S_D4: begin
        if (state_q == S_D1) cmd_o.div_op = DIV_T1_FIRST;
        if (state_q == S_D2) cmd_o.div_op = DIV_T2_FIRST;
        if (state_q == S_D3) cmd_o.div_op = DIV_T1_SECOND;
        if (state_q == S_D4) cmd_o.div_op = DIV_T2_SECOND;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (status_i.div_done) begin
          issued_d = 1'b0;
          if (state_q == S_DCOS)    state_d = S_LOSS;
          else if (state_q == S_D1) state_d = S_D2;
          else if (state_q == S_D2) state_d = S_D3;
          else if (state_q == S_D3) state_d = S_D4;
          else                      state_d = S_GSUB;
        end
      end
      S_LOSS: begin
        cmd_o.loss_ld = 1'b1;
        state_d       = S_RD;
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LD;
      end
      S_LD: begin
        cmd_o.prod_ld = 1'b1;
        state_d       = S_D1;
      end
      S_GSUB: begin
        cmd_o.g_ld = 1'b1;
        state_d    = S_SCL;
      end
      S_SCL: begin
        cmd_o.scale_ld = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (status_i.idx_last) begin
            cmd_o.clr = 1'b1;
            state_d   = S_ACCUM;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      default: begin
        state_d  = S_ACCUM;
        issued_d = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/cosine_embedding_loss_grad.sv =====
// Cosine embedding loss with gradients: one element word per cycle in while accumulating, n words out.
// Input: one word per cycle while accumulating, n words for a vector of length n.
// After the last word: two square roots, a multiply and the cosine divide,
// then for each result four divisions on the shared divider.
// One run at a time: no new word is taken until the last result of the run is emitted.
// Reset clears control and accumulators and restores configuration defaults; stores keep data.
module cosine_embedding_loss_grad import cel_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cel_in_t     in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cel_out_t    out_word_o
);

  cel_cmd_t    cmd;
  cel_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  cel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cel_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
